// ===== design/ialu_pkg.sv =====
// ----------------------------------------------------------------------------
// ialu_pkg: shared types and constants for the integer alu
// opcodes, status codes and the beat that travels down the cell row
// ----------------------------------------------------------------------------
package ialu_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [3:0] OP_ADD = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_MUL = 4'd3;
    localparam logic [3:0] OP_DIV = 4'd4;
    localparam logic [3:0] OP_AND = 4'd5;
    localparam logic [3:0] OP_OR  = 4'd6;
    localparam logic [3:0] OP_NOT = 4'd7;
    localparam logic [3:0] OP_XOR = 4'd8;
    localparam logic [3:0] OP_REM = 4'd9;
    localparam logic [3:0] OP_INC = 4'd10;
    localparam logic [3:0] OP_DEC = 4'd11;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIV0  = 2'd1;
    localparam logic [1:0] ST_BADOP = 2'd2;

    // control carried alongside the data through the cell row
    typedef struct packed {
        logic       vld;
        logic       is_div;   // divide or remainder
        logic       is_rem;   // take the remainder, not the quotient
        logic       neg_q;
        logic       neg_r;
        logic [1:0] st;
    } ialu_ctl_t;

endpackage

// ===== design/ialu_cell.sv =====
// ----------------------------------------------------------------------------
// ialu_cell: one restoring divide step
// shifts the partial remainder, takes one quotient bit, hands on
// ----------------------------------------------------------------------------
module ialu_cell
    import ialu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ialu_ctl_t             ctl_in,
    input  logic [DATA_WIDTH-1:0] rem_in,
    input  logic [DATA_WIDTH-1:0] quo_in,
    input  logic [DATA_WIDTH-1:0] dvs_in,
    input  logic [DATA_WIDTH-1:0] res_in,
    output ialu_ctl_t             ctl_out,
    output logic [DATA_WIDTH-1:0] rem_out,
    output logic [DATA_WIDTH-1:0] quo_out,
    output logic [DATA_WIDTH-1:0] dvs_out,
    output logic [DATA_WIDTH-1:0] res_out
);

    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    ialu_ctl_t             ctl_reg;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [DATA_WIDTH-1:0] dvs_reg, res_reg;

    always_comb
    begin
        trial = {rem_in, quo_in[DATA_WIDTH-1]};
        diff  = trial - {1'b0, dvs_in};
        if (!diff[DATA_WIDTH])
        begin
            rem_next = diff[DATA_WIDTH-1:0];
            quo_next = {quo_in[DATA_WIDTH-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DATA_WIDTH-1:0];
            quo_next = {quo_in[DATA_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_in;
        res_reg <= res_in;
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign dvs_out = dvs_reg;
    assign res_out = res_reg;

endmodule

// ===== design/ialu_front.sv =====
// ----------------------------------------------------------------------------
// ialu_front: decode and simple ops
// registers the non-divide result (multiply included)
// and the divider magnitudes for the cell row
// ----------------------------------------------------------------------------
module ialu_front
    import ialu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [3:0]            func,
    input  logic [DATA_WIDTH-1:0] operand_a,
    input  logic [DATA_WIDTH-1:0] operand_b,
    output ialu_ctl_t             ctl_out,
    output logic [DATA_WIDTH-1:0] quo_out,
    output logic [DATA_WIDTH-1:0] dvs_out,
    output logic [DATA_WIDTH-1:0] res_out
);

    ialu_ctl_t             ctl_reg, ctl_next;
    logic [DATA_WIDTH-1:0] res_reg, res_next;
    logic [DATA_WIDTH-1:0] mag_a_reg, mag_b_reg;
    logic                  na, nb;
    logic [DATA_WIDTH-1:0] one;

    assign na  = operand_a[DATA_WIDTH-1];
    assign nb  = operand_b[DATA_WIDTH-1];
    assign one = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

    always_comb
    begin
        ctl_next        = '0;
        ctl_next.vld    = start;
        ctl_next.st     = ST_OK;
        ctl_next.neg_q  = na ^ nb;
        ctl_next.neg_r  = na;
        res_next        = '0;
        unique case (func)
            OP_ADD: res_next = operand_a + operand_b;
            OP_SUB: res_next = operand_a - operand_b;
            OP_MUL: res_next = operand_a * operand_b;
            OP_AND: res_next = operand_a & operand_b;
            OP_OR:  res_next = operand_a | operand_b;
            OP_NOT: res_next = {{(DATA_WIDTH-1){1'b0}}, (operand_a == '0)};
            OP_XOR: res_next = operand_a ^ operand_b;
            OP_INC: res_next = operand_a + one;
            OP_DEC: res_next = operand_a - one;
            OP_DIV, OP_REM:
            begin
                if (operand_b == '0)
                    ctl_next.st = ST_DIV0;
                else
                begin
                    ctl_next.is_div = 1'b1;
                    ctl_next.is_rem = (func == OP_REM);
                end
            end
            default: ctl_next.st = ST_BADOP;
        endcase
        // reuse the sign flag: remainder wants the dividend sign only
        if (func == OP_REM)
            ctl_next.neg_q = 1'b0;
        else
            ctl_next.neg_r = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_next;
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        mag_a_reg <= na ? -operand_a : operand_a;
        mag_b_reg <= nb ? -operand_b : operand_b;
    end

    assign ctl_out = ctl_reg;
    assign quo_out = mag_a_reg;
    assign dvs_out = mag_b_reg;
    assign res_out = res_reg;

endmodule

// ===== design/integer_alu_eleven_ops_unit.sv =====
// ----------------------------------------------------------------------------
// integer_alu_eleven_ops_unit: signed integer alu, eleven operations
// one beat in per cycle; each result is registered in a front stage,
// then in the row of one-bit restoring divide cells that every beat walks
// through, and then in an output register. done strobes for one
// cycle and the receiver cannot stall; busy is never raised.
// ----------------------------------------------------------------------------
module integer_alu_eleven_ops_unit
    import ialu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [3:0]            func,
    input  logic [DATA_WIDTH-1:0] operand_a,
    input  logic [DATA_WIDTH-1:0] operand_b,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result_value,
    output logic [1:0]            status
);

    ialu_ctl_t             ctl [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rem [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] quo [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] dvs [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] res [0:DATA_WIDTH];

    logic                  done_reg;
    logic [DATA_WIDTH-1:0] result_reg, result_next;
    logic [1:0]            status_reg;

    assign busy   = 1'b0;
    assign rem[0] = '0;

    ialu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .func      (func),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .ctl_out   (ctl[0]),
        .quo_out   (quo[0]),
        .dvs_out   (dvs[0]),
        .res_out   (res[0])
    );

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_cell
        ialu_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl[i]),
            .rem_in  (rem[i]),
            .quo_in  (quo[i]),
            .dvs_in  (dvs[i]),
            .res_in  (res[i]),
            .ctl_out (ctl[i+1]),
            .rem_out (rem[i+1]),
            .quo_out (quo[i+1]),
            .dvs_out (dvs[i+1]),
            .res_out (res[i+1])
        );
    end

    // sign fix of quotient or remainder; non-divide results pass through
    always_comb
    begin
        if (!ctl[DATA_WIDTH].is_div)
            result_next = res[DATA_WIDTH];
        else if (ctl[DATA_WIDTH].is_rem)
            result_next = ctl[DATA_WIDTH].neg_r ? -rem[DATA_WIDTH] : rem[DATA_WIDTH];
        else
            result_next = ctl[DATA_WIDTH].neg_q ? -quo[DATA_WIDTH] : quo[DATA_WIDTH];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctl[DATA_WIDTH].vld;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        status_reg <= ctl[DATA_WIDTH].st;
    end

    assign done         = done_reg;
    assign result_value = result_reg;
    assign status       = status_reg;

endmodule

// ===== sim/tb_integer_alu_eleven_ops_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_alu_eleven_ops_unit: self-checking bench for the integer alu
// directed corner operands, then random operations under several idle
// phases; every done beat is checked against a predicted result queue
// ----------------------------------------------------------------------------
module tb_integer_alu_eleven_ops_unit;
    import ialu_pkg::*;

    localparam int W = 32;
    localparam int WATCHDOG = 2000;

    typedef struct packed {
        logic [3:0]   op;
        logic [W-1:0] a;
        logic [W-1:0] b;
    } alu_cmd_t;

    typedef struct packed {
        logic [W-1:0] value;
        logic [1:0]   st;
    } alu_res_t;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    logic [3:0]   func;
    logic [W-1:0] operand_a;
    logic [W-1:0] operand_b;
    logic         done;
    logic [W-1:0] result_value;
    logic [1:0]   status;

    alu_cmd_t pending_cmds[$];
    alu_res_t expected_results[$];
    int       error_count;
    int       idle_pct;
    int       stall_cycles;
    int       beats_in;
    int       beats_out;
    bit       stim_done;

    integer_alu_eleven_ops_unit #(.DATA_WIDTH(W)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .func(func), .operand_a(operand_a), .operand_b(operand_b),
        .done(done), .result_value(result_value), .status(status)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic alu_res_t alu_compute(alu_cmd_t c);
        alu_res_t   r;
        logic [W-1:0] ma;
        logic [W-1:0] mb;
        logic [W-1:0] q;
        r.st = ST_OK;
        r.value = '0;
        case (c.op)
            OP_ADD: r.value = c.a + c.b;
            OP_SUB: r.value = c.a - c.b;
            OP_MUL: r.value = c.a * c.b;
            OP_AND: r.value = c.a & c.b;
            OP_OR:  r.value = c.a | c.b;
            OP_NOT: r.value = (c.a == '0) ? 1 : 0;
            OP_XOR: r.value = c.a ^ c.b;
            OP_INC: r.value = c.a + 1;
            OP_DEC: r.value = c.a - 1;
            OP_DIV, OP_REM:
            begin
                if (c.b == '0)
                    r.st = ST_DIV0;
                else
                begin
                    // unsigned magnitudes, so min / -1 wraps naturally
                    ma = c.a[W-1] ? -c.a : c.a;
                    mb = c.b[W-1] ? -c.b : c.b;
                    if (c.op == OP_DIV)
                    begin
                        q = ma / mb;
                        r.value = (c.a[W-1] != c.b[W-1]) ? -q : q;
                    end
                    else
                    begin
                        q = ma % mb;
                        r.value = c.a[W-1] ? -q : q;
                    end
                end
            end
            default: r.st = ST_BADOP;
        endcase
        return r;
    endfunction

    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return {1'b1, {(W-1){1'b0}}};
            2: return {1'b0, {(W-1){1'b1}}};
            3: return '1;
            4: return W'($urandom_range(0, 15));
            5: return -W'($urandom_range(1, 15));
            default: return W'($urandom);
        endcase
    endfunction

    task automatic queue_cmd(logic [3:0] op, logic [W-1:0] a, logic [W-1:0] b);
        alu_cmd_t c;
        c.op = op;
        c.a = a;
        c.b = b;
        pending_cmds.push_back(c);
    endtask

    // driver: beats change on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && busy)
        begin
            // hold the beat until accepted
        end
        else if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct)
        begin
            alu_cmd_t c;
            c = pending_cmds.pop_front();
            start <= 1'b1;
            func <= c.op;
            operand_a <= c.a;
            operand_b <= c.b;
        end
        else
        begin
            start <= 1'b0;
            func <= 4'($urandom);
            operand_a <= W'($urandom);
            operand_b <= W'($urandom);
        end
    end

    // monitor: accept and predict inputs, check done beats
    always @(posedge clk)
    begin
        alu_cmd_t c;
        alu_res_t e;
        bit       seen;
        if (rst_n)
        begin
            seen = 1'b0;
            if (start && !busy)
            begin
                c.op = func;
                c.a = operand_a;
                c.b = operand_b;
                expected_results.push_back(alu_compute(c));
                beats_in <= beats_in + 1;
                seen = 1'b1;
            end
            if (done)
            begin
                seen = 1'b1;
                beats_out <= beats_out + 1;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result value=%h status=%0d",
                             $time, result_value, status);
                    error_count <= error_count + 1;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (e.value !== result_value || e.st !== status)
                    begin
                        $display("%0t: mismatch expected value=%h status=%0d %s=%h status=%0d",
                                 $time, e.value, e.st, "actual value",
                                 result_value, status);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (seen)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG)
            begin
                $display("%0t: watchdog timeout", $time);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        logic [W-1:0] minv;
        int n;
        minv = {1'b1, {(W-1){1'b0}}};
        start = 1'b0;
        func = '0;
        operand_a = '0;
        operand_b = '0;
        error_count = 0;
        stall_cycles = 0;
        beats_in = 0;
        beats_out = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners, every opcode and every invalid code
        for (int op = 0; op < 16; op++)
            queue_cmd(4'(op), '1, minv);
        queue_cmd(OP_ADD, {1'b0, {(W-1){1'b1}}}, 1);
        queue_cmd(OP_DIV, minv, '1);
        queue_cmd(OP_REM, minv, '1);
        queue_cmd(OP_DIV, 7, 0);
        queue_cmd(OP_REM, -7, 0);
        queue_cmd(OP_REM, -7, 2);
        queue_cmd(OP_NOT, 0, '1);
        queue_cmd(OP_INC, {1'b0, {(W-1){1'b1}}}, 0);
        queue_cmd(OP_DEC, minv, 0);

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 0) ? 0 : (ph == 2) ? 14 : 49;
            n = 500;
            for (int i = 0; i < n; i++)
            begin
                // mostly valid opcodes, a few invalid ones
                if ($urandom_range(0, 19) == 0)
                    queue_cmd(($urandom_range(0, 1) != 0) ? 4'd0 : 4'($urandom_range(12, 15)),
                              pick_operand(), pick_operand());
                else
                    queue_cmd(4'($urandom_range(1, 11)), pick_operand(), pick_operand());
            end
            while (pending_cmds.size() != 0) @(posedge clk);
        end

        while (expected_results.size() != 0) @(posedge clk);
        repeat (W + 8) @(posedge clk);
        $display("covered %0d operation beats and %0d result beats", beats_in, beats_out);
        $display("all opcodes, invalid codes, divide by zero and overflow corners included");
        if (error_count == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ialu_pkg.sv
design/ialu_cell.sv
design/ialu_front.sv
design/integer_alu_eleven_ops_unit.sv
sim/tb_integer_alu_eleven_ops_unit.sv
